// File: src/vwsp_pkg.sv
// ----------------------------------------------------------------------------
// vwsp_pkg
// Shared types and constants for the variable width sample packer: the
// input and result beat structs and the job record passed between the
// front end and the byte emitter.
// ----------------------------------------------------------------------------
package vwsp_pkg;

  // widest sample the design packs, and the sample field width
  localparam int MAX_SAMPLE_WIDTH = 16;
  localparam int SAMPLE_BITS      = 16;
  localparam int EFF_MAX_WIDTH    = (MAX_SAMPLE_WIDTH < SAMPLE_BITS) ?
                                    MAX_SAMPLE_WIDTH : SAMPLE_BITS;

  // configuration register
  localparam int          CFG_WIDTH_BITS = 5;
  localparam logic [4:0]  WIDTH_RESET    = 5'd9;

  // bytes produced by one sample at most (two full plus a padded tail)
  localparam int JOB_BYTES    = 3;
  localparam int JOB_CNT_BITS = 2;

  // depth of the job queue between front end and emitter
  localparam int JOB_Q_DEPTH = 2;
  localparam int JOB_Q_PTR   = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
  localparam int JOB_Q_CNT   = $clog2(JOB_Q_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_block;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_beat_t;

  // bytes[0] goes out first
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0]  bytes;
    logic [JOB_CNT_BITS-1:0]    nbytes;
    logic                       last;
  } job_t;

endpackage

// File: src/vwsp_front.sv
// ----------------------------------------------------------------------------
// vwsp_front
// Front end: holds the width register and the carried bits, merges each
// accepted sample into the bit stream and hands the finished bytes to the
// job queue as one record.
// ----------------------------------------------------------------------------
module vwsp_front
  import vwsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [CFG_WIDTH_BITS-1:0] cfg_data,
  input  logic                      in_accept,
  input  in_beat_t                  in_data,
  output logic                      job_push,
  output job_t                      job
);

  logic [CFG_WIDTH_BITS-1:0] sample_width_r;
  logic [6:0]                pend_bits_r, pend_bits_nxt;
  logic [2:0]                pend_cnt_r, pend_cnt_nxt;

  logic [4:0]  weff;
  logic [15:0] bits_masked;
  logic [31:0] samp_shift;
  logic [15:0] pend_shift;
  logic [7:0]  pend_left;
  logic [23:0] stream;
  logic [4:0]  count;
  logic [1:0]  nfull;
  logic [2:0]  rem;
  logic        tail;
  logic [7:0]  open_byte;
  logic [15:0] open_shift;

  // effective width saturates at the widest supported sample
  always_comb begin
    if (sample_width_r > 5'(EFF_MAX_WIDTH)) begin
      weff = 5'(EFF_MAX_WIDTH);
    end else begin
      weff = sample_width_r;
    end
  end

  // left align carried bits and sample bits into one 24-bit window
  always_comb begin
    bits_masked = in_data.sample & 16'((17'h1 << weff) - 17'h1);
    samp_shift  = {16'h0, bits_masked} << (5'd16 - weff);
    pend_shift  = {9'h0, pend_bits_r} << (4'd8 - {1'b0, pend_cnt_r});
    pend_left   = pend_shift[7:0];
    stream      = {pend_left, 16'h0} | ({samp_shift[15:0], 8'h0} >> pend_cnt_r);
    count       = {2'b0, pend_cnt_r} + weff;
    nfull       = count[4:3];
    rem         = count[2:0];
    tail        = in_data.end_of_block && (rem != 3'd0);
  end

  // the partly filled byte after the full ones
  always_comb begin
    case (nfull)
      2'd0:    open_byte = stream[23:16];
      2'd1:    open_byte = stream[15:8];
      2'd2:    open_byte = stream[7:0];
      default: open_byte = 8'h00;
    endcase
    open_shift = {8'h0, open_byte} >> (4'd8 - {1'b0, rem});
  end

  // job record for the emitter
  always_comb begin
    job.bytes  = {stream[7:0], stream[15:8], stream[23:16]};
    job.nbytes = nfull + {1'b0, tail};
    job.last   = in_data.end_of_block;
    job_push   = in_accept && (job.nbytes != '0);
  end

  // carried state after this sample
  always_comb begin
    if (in_data.end_of_block) begin
      pend_bits_nxt = 7'h0;
      pend_cnt_nxt  = 3'd0;
    end else begin
      pend_bits_nxt = open_shift[6:0];
      pend_cnt_nxt  = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_width_r <= WIDTH_RESET;
      pend_bits_r    <= 7'h0;
      pend_cnt_r     <= 3'd0;
    end else begin
      if (cfg_valid) begin
        sample_width_r <= cfg_data;
      end
      if (in_accept) begin
        pend_bits_r <= pend_bits_nxt;
        pend_cnt_r  <= pend_cnt_nxt;
      end
    end
  end

endmodule

// File: src/vwsp_job_fifo.sv
// ----------------------------------------------------------------------------
// vwsp_job_fifo
// Short register queue of job records between the front end and the byte
// emitter, so either side can stall on its own.
// ----------------------------------------------------------------------------
module vwsp_job_fifo
  import vwsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t                   mem_r [JOB_Q_DEPTH];
  logic [JOB_Q_PTR-1:0]   wr_ptr_r, rd_ptr_r;
  logic [JOB_Q_CNT-1:0]   cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign full    = (cnt_r == JOB_Q_CNT'(JOB_Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == JOB_Q_PTR'(JOB_Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == JOB_Q_PTR'(JOB_Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// File: src/vwsp_emit.sv
// ----------------------------------------------------------------------------
// vwsp_emit
// Byte emitter: walks the bytes of the queue head job one per cycle, when
// the output register is free or drained, and marks a block's final byte.
// ----------------------------------------------------------------------------
module vwsp_emit
  import vwsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_head,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_beat_t out_data
);

  logic [JOB_CNT_BITS-1:0] idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_r;
  logic                    load, job_done;
  logic [7:0]              cur_byte;

  // pick the current byte of the head job
  always_comb begin
    case (idx_r)
      2'd0:    cur_byte = q_head.bytes[0];
      2'd1:    cur_byte = q_head.bytes[1];
      2'd2:    cur_byte = q_head.bytes[2];
      default: cur_byte = 8'h00;
    endcase
  end

  // load the output register when it is free or being drained
  always_comb begin
    load          = !q_empty && (!out_valid_r || out_pop);
    job_done      = (idx_r == q_head.nbytes - 1'b1);
    q_pop         = load && job_done;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = job_done ? '0 : idx_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_byte  <= cur_byte;
      out_r.last_byte <= q_head.last && job_done;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/variable_width_sample_packer.sv
// ----------------------------------------------------------------------------
// variable_width_sample_packer
// MSB-first packer of variable width IQ samples into a byte stream.
// ----------------------------------------------------------------------------
// Each accepted sample contributes its low sample_width bits (saturated at
// 16) to a continuous bit stream, earlier bits first; every completed byte
// comes out on the result queue, and up to seven leftover bits wait for the
// next sample. A sample flagged end_of_block flushes the tail byte padded
// with zeros and marks the final byte with last_byte. A sample is taken
// while the two-entry job queue has room; bytes leave one per cycle from
// the emitter's output register while the consumer pops, so the sustained
// rate is one sample per cycle when each sample yields at most one byte,
// and is bounded by the byte rate otherwise. Write sample_width only while
// the block is idle.
// ----------------------------------------------------------------------------
module variable_width_sample_packer
  import vwsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_WIDTH_BITS-1:0] cfg_data,
  input  logic                      in_push,
  output logic                      in_full,
  input  in_beat_t                  in_data,
  output logic                      out_empty,
  input  logic                      out_pop,
  output out_beat_t                 out_data
);

  logic in_accept;
  logic job_push;
  job_t job;
  job_t q_head;
  logic q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // sample intake and bit merging
  vwsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_data   (in_data),
    .job_push  (job_push),
    .job       (job)
  );

  // decoupling queue
  vwsp_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // byte output
  vwsp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
